/* rtl/msrr_pkg.sv */
// Shared types and constants for the minimal standard random roll block.
`default_nettype none

package msrr_pkg;

   localparam int unsigned WORD_W = 31;          // generator state, bound and roll width
   localparam int unsigned LO_W   = 16;          // low partial-product slice
   localparam int unsigned HI_W   = 15;          // high partial-product slice
   localparam int unsigned CNT_W  = 5;           // divider step counter

   localparam logic [14:0]       LCG_MULT   = 15'd16807;
   localparam logic [WORD_W-1:0] MODULUS    = 31'h7FFF_FFFF;
   localparam logic [WORD_W-1:0] STATE_SEED = 31'd1;
   localparam logic [CNT_W-1:0]  LAST_STEP  = CNT_W'(WORD_W - 1);

   // Status of a multi-cycle unit as seen by the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } msrr_unit_status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ADVANCE,
      ST_DIVIDE,
      ST_REPLY
   } msrr_state_type;

endpackage

`default_nettype wire

/* rtl/msrr_advance.sv */
// Generator state register and its three-step multiply and end-around reduction.
`default_nettype none

module msrr_advance (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output msrr_pkg::msrr_unit_status_type             status,
   output logic [msrr_pkg::WORD_W-1:0]                gen_state
);

   logic [msrr_pkg::WORD_W-1:0] state_ff, state_in;
   logic [30:0]                 lo_prod_ff, lo_prod_in;
   logic [29:0]                 hi_prod_ff, hi_prod_in;
   logic [32:0]                 sum_ff, sum_in;
   logic [32:0]                 reduced;
   logic                        prod_vld_ff, sum_vld_ff, done_ff;

   // Step 1: two narrow partial products.
   assign lo_prod_in = 31'({16'd0, msrr_pkg::LCG_MULT} *
                           {15'd0, state_ff[msrr_pkg::LO_W-1:0]});
   assign hi_prod_in = 30'({15'd0, msrr_pkg::LCG_MULT} *
                           {15'd0, state_ff[msrr_pkg::WORD_W-1:msrr_pkg::LO_W]});

   // Step 2: fold the high product back in (2^31 wraps to 1).
   assign sum_in = {2'd0, lo_prod_ff}
                 + {2'd0, hi_prod_ff[14:0], 16'd0}
                 + {18'd0, hi_prod_ff[29:15]};

   // Step 3: one conditional subtract, then keep 31 bits.
   always_comb begin
      if (sum_ff > {2'd0, msrr_pkg::MODULUS}) begin
         reduced = sum_ff - {2'd0, msrr_pkg::MODULUS};
      end else begin
         reduced = sum_ff;
      end
      state_in = reduced[msrr_pkg::WORD_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= msrr_pkg::STATE_SEED;
         prod_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         done_ff     <= 1'b0;
      end else begin
         prod_vld_ff <= start;
         sum_vld_ff  <= prod_vld_ff;
         done_ff     <= sum_vld_ff;
         if (sum_vld_ff) begin
            state_ff <= state_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_prod_ff <= lo_prod_in;
      hi_prod_ff <= hi_prod_in;
      sum_ff     <= sum_in;
   end

   assign status.busy = prod_vld_ff | sum_vld_ff;
   assign status.done = done_ff;
   assign gen_state   = state_ff;

endmodule

`default_nettype wire

/* rtl/msrr_divider.sv */
// Restoring remainder unit: one shared compare-and-subtract per cycle.
`default_nettype none

module msrr_divider (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   input  wire logic [msrr_pkg::WORD_W-1:0]           dividend,
   input  wire logic [msrr_pkg::WORD_W-1:0]           divisor,
   output msrr_pkg::msrr_unit_status_type             status,
   output logic [msrr_pkg::WORD_W-1:0]                remainder
);

   logic [msrr_pkg::WORD_W-1:0] rem_ff, rem_in;
   logic [msrr_pkg::WORD_W-1:0] dq_ff;
   logic [msrr_pkg::WORD_W-1:0] dvs_ff;
   logic [msrr_pkg::CNT_W-1:0]  count_ff;
   logic                        busy_ff, done_ff;
   logic [msrr_pkg::WORD_W:0]   trial, diff;
   logic                        fits;

   // Shift in the next dividend bit, subtract if the divisor fits.
   assign trial  = {rem_ff, dq_ff[msrr_pkg::WORD_W-1]};
   assign diff   = trial - {1'b0, dvs_ff};
   assign fits   = (trial >= {1'b0, dvs_ff});
   assign rem_in = fits ? diff[msrr_pkg::WORD_W-1:0] : trial[msrr_pkg::WORD_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         // pulse on the last step
         done_ff <= ~start & busy_ff & (count_ff == '0);
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= msrr_pkg::LAST_STEP;
         end else if (busy_ff) begin
            count_ff <= count_ff - 1'b1;
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         dq_ff  <= dividend;
         dvs_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         dq_ff  <= {dq_ff[msrr_pkg::WORD_W-2:0], 1'b0};
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign remainder   = rem_ff;

endmodule

`default_nettype wire

/* rtl/minimal_standard_random_roll.sv */
// Top level of the minimal standard die roller: sequencer, units and result register.
`default_nettype none

// Each req transaction asks for one roll over 0..range_n-1 and yields exactly one
// rsp transaction. The 31-bit generator starts at 1 after reset and advances by
// state*16807 mod (2^31-1) on every request, including a zero bound. The roll is
// the new state mod range_n; a zero bound returns 0 with the bad_range flag set.
// A request with nonzero bound goes through the multiply/reduce pipeline, the
// bit-serial remainder unit, the hand-over to the reply state and the result load
// before rsp valid; a zero bound skips the remainder unit. The next request is
// taken in the cycle after the result is loaded. The remainder unit does one
// compare-and-subtract per cycle and sets the rate. req_tready is high only while
// the sequencer is idle; a finished result sits in the output register and the
// next request is taken while it waits, though its own result will hold off
// until the earlier one is taken.
module minimal_standard_random_roll (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [30:0] range_n, [31] zero

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [30:0] roll_value, [31] zero
   output logic [0:0]       rsp_tuser    // [0] bad_range
);

   msrr_pkg::msrr_state_type       state_ff, state_in;
   msrr_pkg::msrr_unit_status_type adv_status, div_status;

   logic [msrr_pkg::WORD_W-1:0] gen_state;
   logic [msrr_pkg::WORD_W-1:0] div_rem;
   logic [msrr_pkg::WORD_W-1:0] range_ff;
   logic                        bad_ff;

   logic [msrr_pkg::WORD_W-1:0] roll_ff;
   logic                        roll_bad_ff;
   logic                        rsp_vld_ff;

   logic req_accept;
   logic adv_start;
   logic div_start;
   logic out_free;
   logic out_load;

   assign req_accept = req_tvalid & req_tready;
   assign out_free   = ~rsp_vld_ff | rsp_tready;

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         msrr_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = msrr_pkg::ST_ADVANCE;
            end
         end
         msrr_pkg::ST_ADVANCE: begin
            if (adv_status.done) begin
               state_in = bad_ff ? msrr_pkg::ST_REPLY : msrr_pkg::ST_DIVIDE;
            end
         end
         msrr_pkg::ST_DIVIDE: begin
            if (div_status.done) begin
               state_in = msrr_pkg::ST_REPLY;
            end
         end
         msrr_pkg::ST_REPLY: begin
            if (out_free) begin
               state_in = msrr_pkg::ST_IDLE;
            end
         end
         default: state_in = msrr_pkg::ST_IDLE;
      endcase
   end

   // Output decode of the sequencer.
   always_comb begin
      req_tready = 1'b0;
      adv_start  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      unique case (state_ff)
         msrr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            adv_start  = req_tvalid;
         end
         msrr_pkg::ST_ADVANCE: begin
            div_start = adv_status.done & ~bad_ff;
         end
         msrr_pkg::ST_DIVIDE: begin
         end
         msrr_pkg::ST_REPLY: begin
            out_load = out_free;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= msrr_pkg::ST_IDLE;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
      end
   end

   // Request capture and result register (payload, no reset).
   always_ff @(posedge clock) begin
      if (req_accept) begin
         range_ff <= req_tdata[msrr_pkg::WORD_W-1:0];
         bad_ff   <= (req_tdata[msrr_pkg::WORD_W-1:0] == '0);
      end
      if (out_load) begin
         roll_ff     <= bad_ff ? '0 : div_rem;
         roll_bad_ff <= bad_ff;
      end
   end

   msrr_advance u_advance (
      .clock     (clock),
      .reset     (reset),
      .start     (adv_start),
      .status    (adv_status),
      .gen_state (gen_state)
   );

   msrr_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (gen_state),
      .divisor   (range_ff),
      .status    (div_status),
      .remainder (div_rem)
   );

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = {1'b0, roll_ff};
   assign rsp_tuser[0] = roll_bad_ff;

   // A flagged result always carries a zero roll.
   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == 32'd0)
      else $error("bad_range result with nonzero roll");

   // Remainder is below the bound when the divider finishes.
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> div_rem < range_ff)
      else $error("remainder not below bound");

   // Generator never reaches zero.
   a_state_nonzero: assert property (@(posedge clock) disable iff (reset)
      adv_status.done |-> gen_state != '0)
      else $error("generator state collapsed to zero");

   // The two units never run together.
   a_units_excl: assert property (@(posedge clock) disable iff (reset)
      !(adv_status.busy && div_status.busy))
      else $error("advance and divider busy at once");

endmodule

`default_nettype wire
